// ===== hdl/pcl_pkg.sv =====
// ----------------------------------------------------------------------------
// pcl_pkg: shared types and constants for the positional circular list
// Request and result structs, status and operation codes, and the command
// that the controller broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package pcl_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int MAX_RESULTS  = 32;
	// Count and position width inside the row; covers capacities up to 127.
	localparam int CNT_W        = 7;

	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_END   = 3'd1;
	localparam logic [2:0] OP_INS_POS   = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_END   = 3'd4;
	localparam logic [2:0] OP_DEL_POS   = 3'd5;
	localparam logic [2:0] OP_DUMP      = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] value;
		logic [5:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] result_value;
		logic [4:0]         entry_index;
		logic               last;
	} res_t;

	typedef enum logic [1:0] {
		CM_HOLD   = 2'd0,
		CM_INSERT = 2'd1,
		CM_DELETE = 2'd2,
		CM_ROTATE = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t         mode;
		logic [CNT_W-1:0]   pos;
		logic [CNT_W-1:0]   tail;
		logic signed [31:0] value;
	} cell_cmd_t;

endpackage

// ===== hdl/positional_circular_list.sv =====
// ----------------------------------------------------------------------------
// positional_circular_list: bounded ordered list of signed 32-bit values
// A row of cells holds the entries in order; inserts and deletes shift the
// cells behind the position, and a dump rotates the row.
// ----------------------------------------------------------------------------
//
//  channel   ports                  handshake
//  -------   --------------------   ---------------------------------------
//  request   start, busy, req       taken at a clock edge with start & !busy
//  result    done, result           done marks each result, cannot be stalled
//
// An insert or delete request gives its single result on the following
// cycle; busy stays low, so such requests can come back to back. A dump
// holds busy high while the cell row rotates, and returns one result per
// entry up to MAX_RESULTS, each in the cycle after its rotation; when every
// entry gets a result, the final one shows in the first cycle with busy
// low. The row ends up in its original order. Error cases give one result
// on the next cycle and change nothing. Reset clears the entry count and
// the controller; the cells themselves are not reset. The receiver has no
// way to stall results, so none is ever held back.
// ----------------------------------------------------------------------------
module positional_circular_list #(
	parameter int CAPACITY = pcl_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pcl_pkg::req_t req,
	output logic          done,
	output pcl_pkg::res_t result
);
	import pcl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] MAXR = CNT_W'(MAX_RESULTS);

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   dump_idx_q;
	logic               done_q;
	res_t               result_q;

	logic signed [31:0] cell_val [CAPACITY];
	cell_cmd_t          cmd;

	logic               accept;
	logic [CNT_W-1:0]   req_pos;
	logic [CNT_W-1:0]   tgt_pos;
	logic signed [31:0] sel_val;

	// Next-state of the control path, worked out for every cycle.
	state_t             state_d;
	logic [CNT_W-1:0]   count_d;
	logic [CNT_W-1:0]   dump_idx_d;
	logic               done_d;
	res_t               result_d;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q == S_DUMP);
	assign req_pos = CNT_W'(req.position);

	// The target position of the request: the front, the end, or the one
	// given with the request.
	always_comb begin
		case (req.operation)
			OP_INS_FRONT, OP_DEL_FRONT: tgt_pos = '0;
			OP_INS_END:                 tgt_pos = count_q;
			OP_DEL_END:                 tgt_pos = count_q - CNT_W'(1);
			default:                    tgt_pos = req_pos;
		endcase
	end

	// Entry read at the target position, used for the deleted value. Each
	// cell is gated by its own compare and the results are ORed together.
	always_comb begin
		sel_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (tgt_pos == CNT_W'(i))
				sel_val = sel_val | cell_val[i];
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		dump_idx_d = dump_idx_q;
		done_d     = 1'b0;
		result_d   = '{status: ST_OK, result_value: '0, entry_index: '0, last: 1'b1};
		cmd        = '{mode: CM_HOLD, pos: tgt_pos, tail: count_q - CNT_W'(1),
			value: req.value};

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.operation)
						OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
							done_d = 1'b1;
							if (count_q >= CAP) begin
								result_d.status = ST_FULL;
							end else if (tgt_pos > count_q) begin
								result_d.status = ST_RANGE;
							end else begin
								cmd.mode             = CM_INSERT;
								count_d              = count_q + CNT_W'(1);
								result_d.entry_index = tgt_pos[4:0];
							end
						end
						OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
							done_d = 1'b1;
							if (count_q == '0) begin
								result_d.status = ST_EMPTY;
							end else if (tgt_pos >= count_q) begin
								result_d.status = ST_RANGE;
							end else begin
								cmd.mode              = CM_DELETE;
								count_d               = count_q - CNT_W'(1);
								result_d.result_value = sel_val;
								result_d.entry_index  = tgt_pos[4:0];
							end
						end
						OP_DUMP: begin
							if (count_q == '0) begin
								done_d          = 1'b1;
								result_d.status = ST_EMPTY;
							end else begin
								state_d    = S_DUMP;
								dump_idx_d = '0;
							end
						end
						default: begin
							done_d = 1'b0;
						end
					endcase
				end
			end
			S_DUMP: begin
				// The head cell holds the entry at dump_idx_q; the row rotates
				// left by one every cycle until it is back in order. Entries
				// past the result limit are rotated without a result.
				cmd.mode              = CM_ROTATE;
				done_d                = (dump_idx_q < MAXR);
				result_d.result_value = cell_val[0];
				result_d.entry_index  = dump_idx_q[4:0];
				result_d.last         = (dump_idx_q + CNT_W'(1) == count_q) ||
					(dump_idx_q + CNT_W'(1) == MAXR);
				dump_idx_d            = dump_idx_q + CNT_W'(1);
				if (dump_idx_q + CNT_W'(1) == count_q)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			dump_idx_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			dump_idx_q <= dump_idx_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	// The row of cells. The first cell has no left neighbor and the last
	// has no right neighbor; the head value closes the ring for rotation.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [31:0] left_in;
		logic signed [31:0] right_in;

		if (g == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_mid_l
			assign left_in = cell_val[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_mid_r
			assign right_in = cell_val[g+1];
		end

		pcl_cell #(
			.INDEX(g)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.left (left_in),
			.right(right_in),
			.head (cell_val[0]),
			.value(cell_val[g])
		);
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hdl/pcl_cell.sv =====
// ----------------------------------------------------------------------------
// pcl_cell: one storage cell of the list
// Holds one entry and, per the broadcast command, keeps it, loads the new
// value, or takes the entry of its left or right neighbor or of the head.
// ----------------------------------------------------------------------------
module pcl_cell #(
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  pcl_pkg::cell_cmd_t       cmd,
	input  logic signed [31:0]       left,
	input  logic signed [31:0]       right,
	input  logic signed [31:0]       head,
	output logic signed [31:0]       value
);
	import pcl_pkg::*;

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic signed [31:0] value_q;
	logic signed [31:0] next_value;

	always_comb begin
		next_value = value_q;
		case (cmd.mode)
			CM_INSERT: begin
				if (IDX == cmd.pos)
					next_value = cmd.value;
				else if (IDX > cmd.pos)
					next_value = left;
			end
			CM_DELETE: begin
				if (IDX >= cmd.pos && IDX < cmd.tail)
					next_value = right;
			end
			CM_ROTATE: begin
				if (IDX < cmd.tail)
					next_value = right;
				else if (IDX == cmd.tail)
					next_value = head;
			end
			default: next_value = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= next_value;
	end

	assign value = value_q;

endmodule

// ===== dv/tb_positional_circular_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_circular_list: self-checking bench for the positional list
// The bench drives list requests through the start/busy handshake and keeps
// its own copy of the list. Every result strobe is checked field by field
// against the oldest expected result. A short directed part covers the
// corner cases. Random phases follow that fill, churn and drain the list.
// ----------------------------------------------------------------------------
module tb_positional_circular_list;
	import pcl_pkg::*;

	localparam int LIST_CAP = CAPACITY_DEF;
	// A full dump is the longest single burst of results the block can emit.
	localparam int DRAIN_CYCLES = LIST_CAP + 8;
	localparam int WAIT_LIMIT = 2000;

	// Operation code that the block has no use for; it must be silently dropped.
	localparam logic [2:0] OP_UNUSED = 3'd7;

	localparam logic signed [31:0] VAL_MOST_NEG = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MOST_POS = 32'sh7fff_ffff;
	localparam logic signed [31:0] VAL_ALL_ONES = -32'sd1;
	localparam logic signed [31:0] VAL_ZERO = 32'sd0;

	typedef enum int {
		MIX_FILL,
		MIX_BALANCED,
		MIX_DRAIN
	} mix_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	res_t result;

	// Shadow copy of the list contents, front at index 0.
	logic signed [31:0] list_shadow [$];
	// Results that the block still owes us, oldest first.
	res_t awaited_results [$];

	int unsigned error_count = 0;
	int unsigned requests_sent = 0;
	int unsigned results_seen = 0;
	int unsigned full_refusals = 0;
	int unsigned empty_answers = 0;
	int unsigned burst_left = 0;

	positional_circular_list i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// Update the shadow list for one accepted request and queue the results
	// the block must answer with. Error cases leave the list untouched.
	task automatic list_update(input req_t r);
		int count;
		int pos;
		int n;
		res_t res;
		count = list_shadow.size();
		res = '0;
		res.last = 1'b1;
		case (r.operation)
			OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
				if (r.operation == OP_INS_FRONT) begin
					pos = 0;
				end else if (r.operation == OP_INS_END) begin
					pos = count;
				end else begin
					pos = int'(r.position);
				end
				// A full list refuses every insert, whatever the position.
				if (count >= LIST_CAP) begin
					res.status = ST_FULL;
					full_refusals++;
				end else if (pos > count) begin
					res.status = ST_RANGE;
				end else begin
					list_shadow.insert(pos, r.value);
					res.status = ST_OK;
					res.entry_index = 5'(pos);
				end
				awaited_results.push_back(res);
			end
			OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
				if (r.operation == OP_DEL_FRONT) begin
					pos = 0;
				end else if (r.operation == OP_DEL_END) begin
					pos = (count == 0) ? 0 : count - 1;
				end else begin
					pos = int'(r.position);
				end
				// Emptiness is checked before the position.
				if (count == 0) begin
					res.status = ST_EMPTY;
					empty_answers++;
				end else if (pos >= count) begin
					res.status = ST_RANGE;
				end else begin
					res.status = ST_OK;
					res.result_value = list_shadow[pos];
					res.entry_index = 5'(pos);
					list_shadow.delete(pos);
				end
				awaited_results.push_back(res);
			end
			OP_DUMP: begin
				if (count == 0) begin
					res.status = ST_EMPTY;
					empty_answers++;
					awaited_results.push_back(res);
				end else begin
					n = (count < MAX_RESULTS) ? count : MAX_RESULTS;
					for (int i = 0; i < n; i++) begin
						res.status = ST_OK;
						res.result_value = list_shadow[i];
						res.entry_index = 5'(i);
						res.last = (i == n - 1);
						awaited_results.push_back(res);
					end
				end
			end
			default: begin
				// The unused code is dropped without an answer.
			end
		endcase
	endtask

	// The sender works in bursts. Between bursts it may lower start for a
	// random gap; now and then a long burst runs with no gap at all. A gap of
	// zero leaves start alone so it is never lowered and raised in one step.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 5);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
			                                         : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Present one request and hold it until the block takes it. Must be
	// called in the time step of a rising edge. The busy flag is read right
	// after the edge, so it holds the value the block showed at that edge.
	task automatic send_request(input logic [2:0] op, input logic signed [31:0] val,
	                            input logic [5:0] pos);
		req_t r;
		r.operation = op;
		r.value = val;
		r.position = pos;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		list_update(r);
		requests_sent++;
		pace_sender();
	endtask

	// Every delete and dump on an empty list, plus a positional insert just
	// past the end and the unused code, which must give nothing back.
	task automatic test_empty_list();
		send_request(OP_DUMP, VAL_ZERO, 6'd0);
		send_request(OP_DEL_FRONT, VAL_MOST_POS, 6'd0);
		send_request(OP_DEL_END, VAL_MOST_NEG, 6'd63);
		send_request(OP_DEL_POS, VAL_ALL_ONES, 6'd0);
		send_request(OP_INS_POS, VAL_MOST_POS, 6'd1);
		send_request(OP_UNUSED, VAL_ALL_ONES, 6'd63);
	endtask

	// Inserts of the extreme values at every kind of place, then positions
	// past the end, then a dump of the result.
	task automatic test_extreme_inserts();
		send_request(OP_INS_FRONT, VAL_MOST_NEG, 6'd63);
		send_request(OP_INS_END, VAL_MOST_POS, 6'd0);
		send_request(OP_INS_POS, VAL_ZERO, 6'd1);
		// Position equal to the count appends at the end.
		send_request(OP_INS_POS, VAL_ALL_ONES, 6'd3);
		send_request(OP_INS_POS, 32'sh5555_5555, 6'd5);
		send_request(OP_INS_POS, 32'sh2aaa_aaaa, 6'd63);
		send_request(OP_DUMP, VAL_ZERO, 6'd0);
	endtask

	// Deletes from each place, positions at and beyond the count, and a
	// drain down to an empty list.
	task automatic test_deletes();
		send_request(OP_DEL_POS, VAL_ZERO, 6'd4);
		send_request(OP_DEL_POS, VAL_ZERO, 6'd32);
		send_request(OP_DEL_POS, VAL_ZERO, 6'd1);
		send_request(OP_DEL_FRONT, VAL_ZERO, 6'd0);
		send_request(OP_DEL_END, VAL_ZERO, 6'd0);
		send_request(OP_DUMP, VAL_ZERO, 6'd0);
		send_request(OP_DEL_END, VAL_ZERO, 6'd0);
		send_request(OP_DUMP, VAL_ZERO, 6'd0);
	endtask

	// Random requests whose mix of operations pushes the list toward full,
	// keeps it around the middle, or drains it. Most positions are legal for
	// the current count; the rest span the whole field. The unused code is
	// mixed in as noise and does not count toward the total.
	task automatic test_random_mix(input mix_mode_t mode, input int unsigned total);
		int unsigned done_count;
		int roll;
		int ins_share;
		int del_share;
		int count;
		logic [2:0] op;
		logic [5:0] pos;
		logic signed [31:0] val;
		done_count = 0;
		case (mode)
			MIX_FILL: begin
				ins_share = 85;
				del_share = 8;
			end
			MIX_DRAIN: begin
				ins_share = 15;
				del_share = 78;
			end
			default: begin
				ins_share = 45;
				del_share = 45;
			end
		endcase
		while (done_count < total) begin
			count = list_shadow.size();
			roll = $urandom_range(0, 99);
			if (roll < ins_share) begin
				case ($urandom_range(0, 2))
					0: op = OP_INS_FRONT;
					1: op = OP_INS_END;
					default: op = OP_INS_POS;
				endcase
			end else if (roll < ins_share + del_share) begin
				case ($urandom_range(0, 2))
					0: op = OP_DEL_FRONT;
					1: op = OP_DEL_END;
					default: op = OP_DEL_POS;
				endcase
			end else if (roll < 98) begin
				op = OP_DUMP;
			end else begin
				op = OP_UNUSED;
			end

			if ($urandom_range(0, 4) == 0) begin
				pos = 6'($urandom_range(0, 63));
			end else if (op == OP_INS_POS) begin
				pos = 6'($urandom_range(0, count));
			end else if (count > 0) begin
				pos = 6'($urandom_range(0, count - 1));
			end else begin
				pos = 6'($urandom_range(0, 63));
			end

			case ($urandom_range(0, 11))
				0: val = VAL_MOST_NEG;
				1: val = VAL_MOST_POS;
				2: val = VAL_ALL_ONES;
				3: val = VAL_ZERO;
				default: val = $urandom;
			endcase

			send_request(op, val, pos);
			if (op != OP_UNUSED) begin
				done_count++;
			end
		end
	endtask

	// Result checker. The block cannot be stalled, so every strobe is taken
	// at the edge that ends its cycle and matched against the oldest entry
	// in the expected queue.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d value %0d index %0d last %0b",
				         $time, result.status, result.result_value, result.entry_index,
				         result.last);
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, got %0d",
					         $time, want.status, result.status);
					error_count++;
				end
				if (result.result_value !== want.result_value) begin
					$display("%0t: value mismatch, expected %0d, got %0d",
					         $time, want.result_value, result.result_value);
					error_count++;
				end
				if (result.entry_index !== want.entry_index) begin
					$display("%0t: index mismatch, expected %0d, got %0d",
					         $time, want.entry_index, result.entry_index);
					error_count++;
				end
				if (result.last !== want.last) begin
					$display("%0t: last flag mismatch, expected %0b, got %0b",
					         $time, want.last, result.last);
					error_count++;
				end
			end
		end
	end

	// Main sequence: reset once, directed corners, then rounds of random
	// phases that take the list from empty to full and back again.
	initial begin
		int unsigned wait_count;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_extreme_inserts();
		test_deletes();
		for (int round = 0; round < 3; round++) begin
			test_random_mix(MIX_FILL, 50);
			test_random_mix(MIX_BALANCED, 40);
			test_random_mix(MIX_DRAIN, 30);
		end

		start <= 1'b0;
		wait_count = 0;
		while (awaited_results.size() != 0 && wait_count < WAIT_LIMIT) begin
			@(posedge clk);
			wait_count++;
		end
		// Give any stray strobe a chance to show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived",
			         $time, awaited_results.size());
			error_count++;
		end

		$display("Sent %0d requests and checked %0d results.", requests_sent, results_seen);
		$display("Inserts refused on a full list: %0d; answers from an empty list: %0d.",
		         full_refusals, empty_answers);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this sequence.
	initial begin
		#(2_000_000);
		$display("%0t: run did not finish in time", $time);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
